/* rtl/head_gesture_classifier_assert.svh */
// ----------------------------------------------------------------------------
// head gesture classifier assertion macros
// shared property forms, clocked on clk and held off during reset
// ----------------------------------------------------------------------------
`ifndef HEAD_GESTURE_CLASSIFIER_ASSERT_SVH
`define HEAD_GESTURE_CLASSIFIER_ASSERT_SVH

// same-cycle implication
`define HGC_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define HGC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/hgc_pkg.sv */
// ----------------------------------------------------------------------------
// hgc_pkg
// codes, types and the roll angle table of the head gesture classifier
// ----------------------------------------------------------------------------
package hgc_pkg;

	localparam int CORDIC_STEPS = 21;
	localparam int STEP_BITS    = 5;
	localparam int ANGLE_BITS   = 25;
	localparam int FRAC_BITS    = 16;

	typedef enum logic [3:0] {
		OUT_CONTINUE   = 4'd0,
		OUT_STARTED    = 4'd1,
		OUT_REJECT     = 4'd2,
		OUT_NOISY      = 4'd3,
		OUT_YAW_LEFT   = 4'd4,
		OUT_YAW_RIGHT  = 4'd5,
		OUT_PITCH_UP   = 4'd6,
		OUT_PITCH_DOWN = 4'd7,
		OUT_ROLL_RIGHT = 4'd8,
		OUT_ROLL_LEFT  = 4'd9,
		OUT_IGNORED    = 4'd10
	} outcome_t;

	typedef enum logic [2:0] {
		REJ_RATIO_R = 3'd0,
		REJ_RATIO_L = 3'd1,
		REJ_EYES    = 3'd2,
		REJ_NOSE_R  = 3'd3,
		REJ_NOSE_L  = 3'd4
	} rej_code_t;

	typedef enum logic [2:0] {
		CFG_EYE_MIN   = 3'd0,
		CFG_EYE_MAX   = 3'd1,
		CFG_NOSE_MIN  = 3'd2,
		CFG_NOSE_MAX  = 3'd3,
		CFG_YAW_TRIG  = 3'd4,
		CFG_PITCH_TRIG = 3'd5,
		CFG_ROLL_TRIG = 3'd6,
		CFG_NOISE_LIM = 3'd7
	} cfg_idx_t;

	typedef struct packed {
		logic      fail;
		rej_code_t code;
	} geom_res_t;

	typedef struct packed {
		logic [8:0] eye_min;
		logic [9:0] eye_max;
		logic [8:0] nose_min;
		logic [9:0] nose_max;
	} geom_lim_t;

	// atan(2^-i) in degrees, Q16
	function automatic logic [ANGLE_BITS-1:0] atan_q16(input logic [STEP_BITS-1:0] i);
		logic [ANGLE_BITS-1:0] v;
		case (i)
			5'd0:    v = 25'd2949120;
			5'd1:    v = 25'd1740967;
			5'd2:    v = 25'd919879;
			5'd3:    v = 25'd466945;
			5'd4:    v = 25'd234379;
			5'd5:    v = 25'd117304;
			5'd6:    v = 25'd58666;
			5'd7:    v = 25'd29335;
			5'd8:    v = 25'd14668;
			5'd9:    v = 25'd7334;
			5'd10:   v = 25'd3667;
			5'd11:   v = 25'd1833;
			5'd12:   v = 25'd917;
			5'd13:   v = 25'd458;
			5'd14:   v = 25'd229;
			5'd15:   v = 25'd115;
			5'd16:   v = 25'd57;
			5'd17:   v = 25'd29;
			5'd18:   v = 25'd14;
			5'd19:   v = 25'd7;
			5'd20:   v = 25'd4;
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage

/* rtl/head_gesture_classifier.sv */
// ----------------------------------------------------------------------------
// head_gesture_classifier
// head gesture recogniser working on tracked eye and nose points
// ----------------------------------------------------------------------------
// One word is taken at a time. A start or ignored word goes straight to the
// output phase after acceptance. A tracked frame runs three distance lanes in
// parallel (squares, sum, geometry merge), then the roll cordic, which stops
// early once its residual is zero and otherwise runs all 21 cordic steps; a
// geometry reject skips the cordic. A result waiting in the output register
// does not hold back processing of the next word, only its final hand-over.
module head_gesture_classifier import hgc_pkg::*; #(
	parameter int COORD_BITS = 10,
	parameter int ACC_BITS   = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic                        cmd,
	input  logic [COORD_BITS-1:0]       right_eye_x,
	input  logic [COORD_BITS-1:0]       right_eye_y,
	input  logic [COORD_BITS-1:0]       left_eye_x,
	input  logic [COORD_BITS-1:0]       left_eye_y,
	input  logic [COORD_BITS-1:0]       nose_x,
	input  logic [COORD_BITS-1:0]       nose_y,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [3:0]                  outcome,
	output logic [2:0]                  reject_check,
	output logic signed [COORD_BITS:0]  yaw_value,
	output logic signed [COORD_BITS:0]  pitch_value,
	output logic signed [7:0]           roll_value,
	output logic [2:0]                  noise_value,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [2:0]                  cfg_index,
	input  logic [11:0]                 cfg_data
);

`include "head_gesture_classifier_assert.svh"

	localparam int CW = ((ACC_BITS > 13) ? ACC_BITS : 13) + 1;
	localparam logic signed [ACC_BITS-1:0] ACC_MAX = {1'b0, {(ACC_BITS-1){1'b1}}};
	localparam logic signed [ACC_BITS-1:0] ACC_MIN = {1'b1, {(ACC_BITS-1){1'b0}}};

	typedef enum logic [2:0] {
		S_IDLE, S_SQ, S_SUM, S_GEOM, S_JUDGE, S_ROLL, S_ACC, S_OUT
	} state_t;

	state_t                     state_q;
	outcome_t                   kind_q, dec;
	rej_code_t                  rej_q;
	logic                       active_q, out_valid_q;
	logic [COORD_BITS-1:0]      rx_q, ry_q, lx_q, ly_q, nx_q, ny_q;
	logic [COORD_BITS-1:0]      ref_x_q, ref_y_q;
	logic signed [ACC_BITS-1:0] yaw_acc_q, pitch_acc_q, roll_acc_q;
	logic [2:0]                 noise_q;
	geom_lim_t                  lim_q;
	logic [9:0]                 yaw_trig_q, pitch_trig_q;
	logic [11:0]                roll_trig_q;
	logic [2:0]                 noise_lim_q;
	logic [3:0]                 outcome_q;
	logic [2:0]                 rej_out_q, noise_out_q;
	logic signed [COORD_BITS:0] yaw_out_q, pitch_out_q, yaw, pitch;
	logic signed [7:0]          roll_out_q, roll;
	logic [2*COORD_BITS:0]      e2, r2, l2;
	geom_res_t                  geom;
	logic                       roll_start, roll_done, out_free;
	logic signed [COORD_BITS:0] dx, dy;
	logic                       yaw_in, pitch_in, roll_in;
	logic [1:0]                 ups;
	logic [3:0]                 noise_sum;
	logic [2:0]                 noise_new;
	logic signed [CW-1:0]       yaw_c, pitch_c, roll_c, yt, pt, rt;

	function automatic logic signed [ACC_BITS-1:0] sat_add(
		input logic signed [ACC_BITS-1:0] a,
		input logic signed [7:0] v
	);
		logic signed [ACC_BITS+8:0] s;
		s = (ACC_BITS+9)'(a) + (ACC_BITS+9)'(v);
		if (s > (ACC_BITS+9)'(ACC_MAX))      return ACC_MAX;
		else if (s < (ACC_BITS+9)'(ACC_MIN)) return ACC_MIN;
		else                                 return s[ACC_BITS-1:0];
	endfunction

	// three parallel distance lanes
	hgc_dist_lane #(.COORD_BITS(COORD_BITS)) u_lane_eye (
		.clk(clk), .ax(rx_q), .ay(ry_q), .bx(lx_q), .by(ly_q), .d2(e2)
	);
	hgc_dist_lane #(.COORD_BITS(COORD_BITS)) u_lane_rnose (
		.clk(clk), .ax(rx_q), .ay(ry_q), .bx(nx_q), .by(ny_q), .d2(r2)
	);
	hgc_dist_lane #(.COORD_BITS(COORD_BITS)) u_lane_lnose (
		.clk(clk), .ax(lx_q), .ay(ly_q), .bx(nx_q), .by(ny_q), .d2(l2)
	);

	hgc_geom_check #(.COORD_BITS(COORD_BITS)) u_geom (
		.clk(clk), .e2(e2), .r2(r2), .l2(l2), .lim(lim_q), .res(geom)
	);

	assign dx = $signed({1'b0, lx_q}) - $signed({1'b0, rx_q});
	assign dy = $signed({1'b0, ly_q}) - $signed({1'b0, ry_q});
	assign roll_start = (state_q == S_JUDGE) && !geom.fail;

	hgc_roll_cordic #(.COORD_BITS(COORD_BITS)) u_roll (
		.clk(clk), .arst_n(arst_n), .start(roll_start), .dx(dx), .dy(dy),
		.done(roll_done), .roll(roll)
	);

	assign yaw   = $signed({1'b0, ref_x_q}) - $signed({1'b0, nx_q});
	assign pitch = $signed({1'b0, ny_q}) - $signed({1'b0, ref_y_q});

	// banding and noise
	always_comb begin
		yaw_in   = (yaw != '0) && (yaw > -20) && (yaw < 20);
		pitch_in = (pitch != '0) && (pitch > -20) && (pitch < 20);
		roll_in  = ((roll > -60) && (roll < -15)) || ((roll > 15) && (roll < 60));
		ups = 2'd0;
		if (!yaw_in && ((yaw < -40) || (yaw > 40)))         ups = ups + 2'd1;
		if (!pitch_in && ((pitch < -40) || (pitch > 40)))   ups = ups + 2'd1;
		if (!roll_in && ((roll < -60) || (roll > 60)))      ups = ups + 2'd1;
		noise_sum = {1'b0, noise_q} + {2'b00, ups};
		noise_new = (noise_sum > 4'd7) ? 3'd7 : noise_sum[2:0];
	end

	// gesture decision on the updated accumulators
	always_comb begin
		yaw_c   = CW'(yaw_acc_q);
		pitch_c = CW'(pitch_acc_q);
		roll_c  = CW'(roll_acc_q);
		yt = $signed(CW'(yaw_trig_q));
		pt = $signed(CW'(pitch_trig_q));
		rt = $signed(CW'(roll_trig_q));
		dec = OUT_CONTINUE;
		if (noise_q > noise_lim_q) dec = OUT_NOISY;
		else if (roll_acc_q == '0) begin
			if (yaw_c <= -yt)        dec = OUT_YAW_LEFT;
			else if (yaw_c >= yt)    dec = OUT_YAW_RIGHT;
			else if (pitch_c <= -pt) dec = OUT_PITCH_UP;
			else if (pitch_c >= pt)  dec = OUT_PITCH_DOWN;
		end else begin
			if (roll_c < -rt)        dec = OUT_ROLL_RIGHT;
			else if (roll_c > rt)    dec = OUT_ROLL_LEFT;
		end
	end

	assign out_free = !out_valid_q || !out_stall;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lim_q.eye_min  <= 9'd20;
			lim_q.eye_max  <= 10'd160;
			lim_q.nose_min <= 9'd10;
			lim_q.nose_max <= 10'd140;
			yaw_trig_q     <= 10'd20;
			pitch_trig_q   <= 10'd15;
			roll_trig_q    <= 12'd120;
			noise_lim_q    <= 3'd2;
		end else if (cfg_valid) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_EYE_MIN:    lim_q.eye_min  <= cfg_data[8:0];
				CFG_EYE_MAX:    lim_q.eye_max  <= cfg_data[9:0];
				CFG_NOSE_MIN:   lim_q.nose_min <= cfg_data[8:0];
				CFG_NOSE_MAX:   lim_q.nose_max <= cfg_data[9:0];
				CFG_YAW_TRIG:   yaw_trig_q     <= cfg_data[9:0];
				CFG_PITCH_TRIG: pitch_trig_q   <= cfg_data[9:0];
				CFG_ROLL_TRIG:  roll_trig_q    <= cfg_data;
				CFG_NOISE_LIM:  noise_lim_q    <= cfg_data[2:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			active_q    <= 1'b0;
			out_valid_q <= 1'b0;
			ref_x_q     <= '0;
			ref_y_q     <= '0;
			yaw_acc_q   <= '0;
			pitch_acc_q <= '0;
			roll_acc_q  <= '0;
			noise_q     <= '0;
			kind_q      <= OUT_CONTINUE;
			rej_q       <= REJ_RATIO_R;
		end else begin
			// the output phase reloads the register itself
			if (out_valid_q && !out_stall && (state_q != S_OUT)) out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						rx_q <= right_eye_x;
						ry_q <= right_eye_y;
						lx_q <= left_eye_x;
						ly_q <= left_eye_y;
						nx_q <= nose_x;
						ny_q <= nose_y;
						if (!cmd) begin
							kind_q  <= OUT_STARTED;
							state_q <= S_OUT;
						end else if (!active_q) begin
							kind_q  <= OUT_IGNORED;
							state_q <= S_OUT;
						end else begin
							kind_q  <= OUT_CONTINUE;
							state_q <= S_SQ;
						end
					end
				end
				S_SQ:   state_q <= S_SUM;
				S_SUM:  state_q <= S_GEOM;
				S_GEOM: state_q <= S_JUDGE;
				S_JUDGE: begin
					if (geom.fail) begin
						kind_q  <= OUT_REJECT;
						rej_q   <= geom.code;
						state_q <= S_OUT;
					end else begin
						state_q <= S_ROLL;
					end
				end
				S_ROLL: begin
					if (roll_done) state_q <= S_ACC;
				end
				S_ACC: begin
					yaw_acc_q   <= yaw_in ? sat_add(yaw_acc_q, 8'(yaw)) : '0;
					pitch_acc_q <= pitch_in ? sat_add(pitch_acc_q, 8'(pitch)) : '0;
					roll_acc_q  <= roll_in ? sat_add(roll_acc_q, roll) : '0;
					noise_q     <= noise_new;
					state_q     <= S_OUT;
				end
				S_OUT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						rej_out_q   <= '0;
						yaw_out_q   <= '0;
						pitch_out_q <= '0;
						roll_out_q  <= '0;
						noise_out_q <= noise_q;
						state_q     <= S_IDLE;
						case (kind_q)
							OUT_STARTED: begin
								outcome_q   <= OUT_STARTED;
								noise_out_q <= '0;
								active_q    <= 1'b1;
								ref_x_q     <= nx_q;
								ref_y_q     <= ny_q;
								yaw_acc_q   <= '0;
								pitch_acc_q <= '0;
								roll_acc_q  <= '0;
								noise_q     <= '0;
							end
							OUT_IGNORED: outcome_q <= OUT_IGNORED;
							OUT_REJECT: begin
								outcome_q <= OUT_REJECT;
								rej_out_q <= rej_q;
								active_q  <= 1'b0;
							end
							default: begin
								outcome_q   <= dec;
								yaw_out_q   <= yaw;
								pitch_out_q <= pitch;
								roll_out_q  <= roll;
								if (dec != OUT_CONTINUE) active_q <= 1'b0;
								else begin
									ref_x_q <= nx_q;
									ref_y_q <= ny_q;
								end
							end
						endcase
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign in_stall     = (state_q != S_IDLE);
	assign cfg_ready    = 1'b1;
	assign out_valid    = out_valid_q;
	assign outcome      = outcome_q;
	assign reject_check = rej_out_q;
	assign yaw_value    = yaw_out_q;
	assign pitch_value  = pitch_out_q;
	assign roll_value   = roll_out_q;
	assign noise_value  = noise_out_q;

	`HGC_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "accepted word did not start work")
	`HGC_ASSERT_SAME(a_roll_done_in_roll, roll_done, state_q == S_ROLL, "cordic finished outside roll phase")
	`HGC_ASSERT_SAME(a_reject_code_clean, out_valid && (outcome != OUT_REJECT), reject_check == '0, "reject code on non-reject result")

endmodule

/* rtl/hgc_dist_lane.sv */
// ----------------------------------------------------------------------------
// hgc_dist_lane
// squared distance between two points, two pipeline stages
// ----------------------------------------------------------------------------
module hgc_dist_lane #(
	parameter int COORD_BITS = 10
) (
	input  logic                    clk,
	input  logic [COORD_BITS-1:0]   ax,
	input  logic [COORD_BITS-1:0]   ay,
	input  logic [COORD_BITS-1:0]   bx,
	input  logic [COORD_BITS-1:0]   by,
	output logic [2*COORD_BITS:0]   d2
);

	logic signed [COORD_BITS:0]     dx, dy;
	logic signed [2*COORD_BITS+1:0] px, py;
	logic [2*COORD_BITS-1:0]        sqx_s1, sqy_s1;
	logic [2*COORD_BITS:0]          d2_s2;

	assign dx = $signed({1'b0, ax}) - $signed({1'b0, bx});
	assign dy = $signed({1'b0, ay}) - $signed({1'b0, by});
	assign px = dx * dx;
	assign py = dy * dy;

	always_ff @(posedge clk) begin
		sqx_s1 <= px[2*COORD_BITS-1:0];
		sqy_s1 <= py[2*COORD_BITS-1:0];
		d2_s2  <= {1'b0, sqx_s1} + {1'b0, sqy_s1};
	end

	assign d2 = d2_s2;

endmodule

/* rtl/hgc_geom_check.sv */
// ----------------------------------------------------------------------------
// hgc_geom_check
// merges the three lane distances into a geometry verdict
// ----------------------------------------------------------------------------
module hgc_geom_check import hgc_pkg::*; #(
	parameter int COORD_BITS = 10
) (
	input  logic                  clk,
	input  logic [2*COORD_BITS:0] e2,
	input  logic [2*COORD_BITS:0] r2,
	input  logic [2*COORD_BITS:0] l2,
	input  geom_lim_t             lim,
	output geom_res_t             res
);

	localparam int DW = 2*COORD_BITS + 1;
	localparam int XW = DW + 6;

	logic [17:0]   eye_lo_s1, nose_lo_s1;
	logic [19:0]   eye_hi_s1, nose_hi_s1;
	logic [XW-1:0] e4, r49, l49, ex, rx, lx;
	logic [XW-1:0] elo, ehi, nlo, nhi;
	logic          rat_r, rat_l, bad_e, bad_r, bad_l;
	geom_res_t     res_s2, res_d;

	// limit squares follow the registers, which the user must change only while idle; the block does not enforce it
	always_ff @(posedge clk) begin
		eye_lo_s1  <= 18'(lim.eye_min) * 18'(lim.eye_min);
		eye_hi_s1  <= 20'(lim.eye_max) * 20'(lim.eye_max);
		nose_lo_s1 <= 18'(lim.nose_min) * 18'(lim.nose_min);
		nose_hi_s1 <= 20'(lim.nose_max) * 20'(lim.nose_max);
	end

	assign ex  = XW'(e2);
	assign rx  = XW'(r2);
	assign lx  = XW'(l2);
	assign e4  = ex << 2;
	assign r49 = (rx << 5) + (rx << 4) + rx;
	assign l49 = (lx << 5) + (lx << 4) + lx;
	assign elo = XW'(eye_lo_s1);
	assign ehi = XW'(eye_hi_s1);
	assign nlo = XW'(nose_lo_s1);
	assign nhi = XW'(nose_hi_s1);

	assign rat_r = (e4 < rx) || (e4 > r49);
	assign rat_l = (e4 < lx) || (e4 > l49);
	assign bad_e = (ex > ehi) || (ex < elo);
	assign bad_r = (rx > nhi) || (rx < nlo);
	assign bad_l = (lx > nhi) || (lx < nlo);

	always_comb begin
		res_d.fail = 1'b1;
		if (rat_r)      res_d.code = REJ_RATIO_R;
		else if (rat_l) res_d.code = REJ_RATIO_L;
		else if (bad_e) res_d.code = REJ_EYES;
		else if (bad_r) res_d.code = REJ_NOSE_R;
		else if (bad_l) res_d.code = REJ_NOSE_L;
		else begin
			res_d.fail = 1'b0;
			res_d.code = REJ_RATIO_R;
		end
	end

	always_ff @(posedge clk) begin
		res_s2 <= res_d;
	end

	assign res = res_s2;

endmodule

/* rtl/hgc_roll_cordic.sv */
// ----------------------------------------------------------------------------
// hgc_roll_cordic
// eye line angle by iterative cordic vectoring, one step per cycle
// ----------------------------------------------------------------------------
module hgc_roll_cordic import hgc_pkg::*; #(
	parameter int COORD_BITS = 10
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic signed [COORD_BITS:0] dx,
	input  logic signed [COORD_BITS:0] dy,
	output logic                     done,
	output logic signed [7:0]        roll
);

	localparam int W = COORD_BITS + FRAC_BITS + 3;

	logic                         busy_q, done_q, neg_q;
	logic [STEP_BITS-1:0]         i_q;
	logic signed [W-1:0]          x_q, y_q, xs, ys;
	logic signed [ANGLE_BITS-1:0] z_q, za;
	logic signed [7:0]            roll_q, fin;
	logic [COORD_BITS:0]          mx, my;
	logic [ANGLE_BITS-FRAC_BITS-1:0] deg;

	assign mx = dx[COORD_BITS] ? (COORD_BITS+1)'(-dx) : dx;
	assign my = dy[COORD_BITS] ? (COORD_BITS+1)'(-dy) : dy;
	assign xs = x_q >>> i_q;
	assign ys = y_q >>> i_q;
	assign za = $signed(atan_q16(i_q));

	always_comb begin
		if (z_q[ANGLE_BITS-1]) deg = '0;
		else                   deg = z_q[ANGLE_BITS-1:FRAC_BITS];
		if (deg > (ANGLE_BITS-FRAC_BITS)'(90)) fin = 8'sd90;
		else                                  fin = $signed(deg[7:0]);
		if (neg_q) fin = -fin;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				neg_q <= dx[COORD_BITS] != dy[COORD_BITS];
				if (dx == '0) begin
					// vertical eye line
					done_q <= 1'b1;
					if (dy > 0)      roll_q <= 8'sd90;
					else if (dy < 0) roll_q <= -8'sd90;
					else             roll_q <= 8'sd0;
				end else begin
					busy_q <= 1'b1;
					i_q    <= '0;
					x_q    <= $signed({{(W-COORD_BITS-1-FRAC_BITS){1'b0}}, mx, {FRAC_BITS{1'b0}}});
					y_q    <= $signed({{(W-COORD_BITS-1-FRAC_BITS){1'b0}}, my, {FRAC_BITS{1'b0}}});
					z_q    <= '0;
				end
			end else if (busy_q) begin
				if (y_q == '0 || i_q == STEP_BITS'(CORDIC_STEPS)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
					roll_q <= fin;
				end else begin
					if (y_q > 0) begin
						x_q <= x_q + ys;
						y_q <= y_q - xs;
						z_q <= z_q + za;
					end else begin
						x_q <= x_q - ys;
						y_q <= y_q + xs;
						z_q <= z_q - za;
					end
					i_q <= i_q + 1'b1;
				end
			end
		end
	end

	assign done = done_q;
	assign roll = roll_q;

endmodule

/* tb/testbench.sv */
// ----------------------------------------------------------------------------
// head gesture classifier testbench
// drives start and tracked frame words with random gaps and output stalls,
// predicts every result from its own model of the classifier and checks
// each result field by field in arrival order
// ----------------------------------------------------------------------------
module testbench;
	import hgc_pkg::*;

	typedef struct {
		outcome_t          outcome;
		logic [2:0]        reject_check;
		logic signed [10:0] yaw;
		logic signed [10:0] pitch;
		logic signed [7:0] roll;
		logic [2:0]        noise;
	} gesture_t;

	localparam longint ACC_HI = 32767;
	localparam longint ACC_LO = -32768;
	localparam longint ATAN_DEG[21] = '{
		2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
		14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7, 4
	};
	localparam int REG_WIDTH[8] = '{9, 10, 9, 10, 10, 10, 12, 3};

	logic clk, arst_n;
	logic in_valid, in_stall, cmd;
	logic [9:0] right_eye_x, right_eye_y, left_eye_x, left_eye_y, nose_x, nose_y;
	logic out_valid, out_stall;
	logic [3:0] outcome;
	logic [2:0] reject_check;
	logic signed [10:0] yaw_value, pitch_value;
	logic signed [7:0] roll_value;
	logic [2:0] noise_value;
	logic cfg_valid, cfg_ready;
	logic [2:0] cfg_index;
	logic [11:0] cfg_data;

	// predictor state
	int limits[8];
	bit active;
	int ref_x, ref_y;
	longint acc_yaw, acc_pitch, acc_roll;
	int noise_cnt;

	gesture_t expected_q[$];
	int errors;
	int send_idle, recv_idle;
	bit hold_req;
	int hold_left;

	head_gesture_classifier dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .cmd(cmd),
		.right_eye_x(right_eye_x), .right_eye_y(right_eye_y),
		.left_eye_x(left_eye_x), .left_eye_y(left_eye_y),
		.nose_x(nose_x), .nose_y(nose_y),
		.out_valid(out_valid), .out_stall(out_stall),
		.outcome(outcome), .reject_check(reject_check),
		.yaw_value(yaw_value), .pitch_value(pitch_value),
		.roll_value(roll_value), .noise_value(noise_value),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	initial begin
		clk = 0;
	end
	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	function automatic longint sat_add(longint a, longint v);
		longint s;
		s = a + v;
		if (s > ACC_HI) s = ACC_HI;
		if (s < ACC_LO) s = ACC_LO;
		return s;
	endfunction

	function automatic bit outside(longint d2, longint lo, longint hi);
		return d2 > hi * hi || d2 < lo * lo;
	endfunction

	function automatic void bump_noise();
		if (noise_cnt < 7) noise_cnt++;
	endfunction

	function automatic gesture_t classify(bit c, longint rx, longint ry, longint lx,
			longint ly, longint nx, longint ny);
		gesture_t g;
		longint e2, r2, l2, yaw, pitch, roll, x, y, z, xs, ys, dx, dy;
		int rej;
		bit neg;
		g.outcome = OUT_CONTINUE;
		g.reject_check = 0;
		g.yaw = 0;
		g.pitch = 0;
		g.roll = 0;
		g.noise = 0;
		if (!c) begin
			active = 1;
			ref_x = nx;
			ref_y = ny;
			acc_yaw = 0;
			acc_pitch = 0;
			acc_roll = 0;
			noise_cnt = 0;
			g.outcome = OUT_STARTED;
			return g;
		end
		if (!active) begin
			g.outcome = OUT_IGNORED;
			g.noise = noise_cnt;
			return g;
		end
		e2 = (rx - lx) * (rx - lx) + (ry - ly) * (ry - ly);
		r2 = (rx - nx) * (rx - nx) + (ry - ny) * (ry - ny);
		l2 = (lx - nx) * (lx - nx) + (ly - ny) * (ly - ny);
		rej = -1;
		if (4 * e2 < r2 || 4 * e2 > 49 * r2) rej = REJ_RATIO_R;
		else if (4 * e2 < l2 || 4 * e2 > 49 * l2) rej = REJ_RATIO_L;
		else if (outside(e2, limits[CFG_EYE_MIN], limits[CFG_EYE_MAX])) rej = REJ_EYES;
		else if (outside(r2, limits[CFG_NOSE_MIN], limits[CFG_NOSE_MAX])) rej = REJ_NOSE_R;
		else if (outside(l2, limits[CFG_NOSE_MIN], limits[CFG_NOSE_MAX])) rej = REJ_NOSE_L;
		if (rej >= 0) begin
			active = 0;
			g.outcome = OUT_REJECT;
			g.reject_check = rej;
			g.noise = noise_cnt;
			return g;
		end

		// eye line angle by cordic vectoring in q16 degrees
		dx = lx - rx;
		dy = ly - ry;
		if (dx == 0) begin
			roll = dy > 0 ? 90 : (dy < 0 ? -90 : 0);
		end else begin
			neg = (dx < 0) != (dy < 0);
			x = (dx < 0 ? -dx : dx) * 65536;
			y = (dy < 0 ? -dy : dy) * 65536;
			z = 0;
			for (int i = 0; i < 21; i++) begin
				if (y == 0) break;
				xs = x >>> i;
				ys = y >>> i;
				if (y > 0) begin
					x += ys;
					y -= xs;
					z += ATAN_DEG[i];
				end else begin
					x -= ys;
					y += xs;
					z -= ATAN_DEG[i];
				end
			end
			if (z < 0) z = 0;
			roll = z >>> 16;
			if (roll > 90) roll = 90;
			if (neg) roll = -roll;
		end
		yaw = ref_x - nx;
		pitch = ny - ref_y;

		if (yaw != 0 && yaw > -20 && yaw < 20) begin
			acc_yaw = sat_add(acc_yaw, yaw);
		end else begin
			acc_yaw = 0;
			if (yaw < -40 || yaw > 40) bump_noise();
		end
		if (pitch != 0 && pitch > -20 && pitch < 20) begin
			acc_pitch = sat_add(acc_pitch, pitch);
		end else begin
			acc_pitch = 0;
			if (pitch < -40 || pitch > 40) bump_noise();
		end
		if ((roll > -60 && roll < -15) || (roll > 15 && roll < 60)) begin
			acc_roll = sat_add(acc_roll, roll);
		end else begin
			acc_roll = 0;
			if (roll < -60 || roll > 60) bump_noise();
		end
		g.yaw = yaw;
		g.pitch = pitch;
		g.roll = roll;
		g.noise = noise_cnt;

		if (noise_cnt > limits[CFG_NOISE_LIM]) begin
			g.outcome = OUT_NOISY;
		end else if (acc_roll == 0) begin
			if (acc_yaw <= -limits[CFG_YAW_TRIG]) g.outcome = OUT_YAW_LEFT;
			else if (acc_yaw >= limits[CFG_YAW_TRIG]) g.outcome = OUT_YAW_RIGHT;
			else if (acc_pitch <= -limits[CFG_PITCH_TRIG]) g.outcome = OUT_PITCH_UP;
			else if (acc_pitch >= limits[CFG_PITCH_TRIG]) g.outcome = OUT_PITCH_DOWN;
		end else begin
			if (acc_roll < -limits[CFG_ROLL_TRIG]) g.outcome = OUT_ROLL_RIGHT;
			else if (acc_roll > limits[CFG_ROLL_TRIG]) g.outcome = OUT_ROLL_LEFT;
		end
		if (g.outcome != OUT_CONTINUE) begin
			active = 0;
		end else begin
			ref_x = nx;
			ref_y = ny;
		end
		return g;
	endfunction

	task automatic report_mismatch(string field, longint got, longint want);
		$display("mismatch %s: got %0d want %0d at %0t", field, got, want, $realtime);
		errors++;
	endtask

	// result checker
	always @(posedge clk) begin
		gesture_t w;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_q.size() == 0) begin
				report_mismatch("unexpected word", outcome, -1);
			end else begin
				w = expected_q.pop_front();
				if (outcome !== w.outcome) report_mismatch("outcome", outcome, w.outcome);
				if (reject_check !== w.reject_check)
					report_mismatch("reject_check", reject_check, w.reject_check);
				if (yaw_value !== w.yaw) report_mismatch("yaw_value", yaw_value, w.yaw);
				if (pitch_value !== w.pitch)
					report_mismatch("pitch_value", pitch_value, w.pitch);
				if (roll_value !== w.roll) report_mismatch("roll_value", roll_value, w.roll);
				if (noise_value !== w.noise)
					report_mismatch("noise_value", noise_value, w.noise);
			end
		end
	end

	// receiver stalls, with a long hold-off on request
	always @(posedge clk) begin
		if (hold_req) begin
			hold_left = 300;
			hold_req = 0;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1;
		end else begin
			out_stall <= $urandom_range(99) < recv_idle;
		end
	end

	task automatic send_word(bit c, int rx, int ry, int lx, int ly, int nx, int ny);
		while ($urandom_range(99) < send_idle) begin
			in_valid <= 0;
			@(posedge clk);
		end
		in_valid <= 1;
		cmd <= c;
		right_eye_x <= rx;
		right_eye_y <= ry;
		left_eye_x <= lx;
		left_eye_y <= ly;
		nose_x <= nx;
		nose_y <= ny;
		forever begin
			@(posedge clk);
			if (!in_stall) break;
		end
		expected_q.push_back(classify(c, rx, ry, lx, ly, nx, ny));
	endtask

	function automatic int clip(int v);
		return v < 0 ? 0 : (v > 1023 ? 1023 : v);
	endfunction

	// face built from the right eye and the eye line, nose below its middle
	task automatic send_face(bit c, int cx, int cy, int dx, int dy);
		send_word(c, clip(cx), clip(cy), clip(cx + dx), clip(cy + dy),
			clip(cx + dx / 2 - dy * 3 / 4), clip(cy + dy / 2 + dx * 3 / 4));
	endtask

	task automatic drain();
		in_valid <= 0;
		while (expected_q.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic write_reg(cfg_idx_t idx, int value);
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data <= value;
		forever begin
			@(posedge clk);
			if (cfg_ready) break;
		end
		limits[idx] = value & ((1 << REG_WIDTH[idx]) - 1);
	endtask

	task automatic set_all(int em, int eM, int nm, int nM, int yt, int pt, int rt, int nl);
		write_reg(CFG_EYE_MIN, em);
		write_reg(CFG_EYE_MAX, eM);
		write_reg(CFG_NOSE_MIN, nm);
		write_reg(CFG_NOSE_MAX, nM);
		write_reg(CFG_YAW_TRIG, yt);
		write_reg(CFG_PITCH_TRIG, pt);
		write_reg(CFG_ROLL_TRIG, rt);
		write_reg(CFG_NOISE_LIM, nl);
		cfg_valid <= 0;
		@(posedge clk);
	endtask

	task automatic test_directed();
		send_word(1, 0, 0, 0, 0, 0, 0);
		send_word(1, 1023, 1023, 1023, 1023, 1023, 1023);
		send_word(0, 1023, 1023, 1023, 1023, 1023, 1023);
		// coincident points pass the ratios, fail on eye distance
		send_word(1, 1023, 1023, 1023, 1023, 1023, 1023);
		send_face(0, 400, 400, 60, 0);
		send_face(1, 400, 400, 60, 0);
		send_face(1, 390, 400, 60, 0);
		send_face(1, 380, 400, 60, 0);
		send_face(0, 400, 400, 60, 0);
		send_face(1, 410, 400, 60, 0);
		send_face(1, 420, 400, 60, 0);
		send_face(0, 400, 400, 60, 0);
		send_face(1, 400, 410, 60, 0);
		send_face(0, 400, 400, 60, 0);
		send_face(0, 400, 400, 60, 0);
		send_face(1, 400, 392, 60, 0);
		send_face(1, 400, 384, 60, 0);
		send_face(0, 400, 400, 60, 0);
		repeat (3) send_face(1, 400, 400, 60, 60);
		send_face(0, 400, 400, 60, 0);
		repeat (3) send_face(1, 400, 400, 60, -60);
		// vertical eye lines, both senses, run into noise
		send_face(0, 400, 400, 60, 0);
		send_word(1, 400, 400, 400, 460, 355, 430);
		send_word(1, 400, 460, 400, 400, 445, 430);
		send_word(1, 400, 460, 400, 400, 445, 430);
		drain();
	endtask

	task automatic random_session();
		int cx, cy, dx, dy, frames;
		cx = $urandom_range(150, 750);
		cy = $urandom_range(150, 750);
		dx = $urandom_range(25, 100);
		dy = $urandom_range(0, dx) - dx / 2;
		if ($urandom_range(9) == 0) dx = -dx;
		send_face(0, cx, cy, dx, dy);
		frames = $urandom_range(2, 12);
		repeat (frames) begin
			if ($urandom_range(7) == 0) cx += $urandom_range(0, 120) - 60;
			else cx += $urandom_range(0, 30) - 15;
			if ($urandom_range(7) == 0) cy += $urandom_range(0, 120) - 60;
			else cy += $urandom_range(0, 30) - 15;
			case ($urandom_range(5))
				0: dy = $urandom_range(0, 2 * (dx < 0 ? -dx : dx)) - (dx < 0 ? -dx : dx);
				1: dy = dy + $urandom_range(0, 20) - 10;
				default: ;
			endcase
			if ($urandom_range(19) == 0)
				send_word(1, $urandom_range(1023), $urandom_range(1023),
					$urandom_range(1023), $urandom_range(1023),
					$urandom_range(1023), $urandom_range(1023));
			else
				send_face(1, cx, cy, dx, dy);
		end
	endtask

	task automatic test_random(int words);
		while (words > 0) begin
			if ($urandom_range(9) < 8) begin
				random_session();
				words -= 8;
			end else begin
				send_word($urandom_range(1), $urandom_range(1023), $urandom_range(1023),
					$urandom_range(1023), $urandom_range(1023),
					$urandom_range(1023), $urandom_range(1023));
				words--;
			end
		end
		drain();
	endtask

	task automatic test_backpressure();
		hold_req = 1;
		repeat (30) random_session();
		drain();
		// sender waits for all results of a session before going on
		random_session();
		drain();
		random_session();
		drain();
	endtask

	initial begin
		errors = 0;
		active = 0;
		ref_x = 0;
		ref_y = 0;
		acc_yaw = 0;
		acc_pitch = 0;
		acc_roll = 0;
		noise_cnt = 0;
		limits = '{20, 160, 10, 140, 20, 15, 120, 2};
		hold_req = 0;
		hold_left = 0;
		send_idle = 29;
		recv_idle = 78;
		arst_n <= 0;
		in_valid <= 0;
		cmd <= 0;
		right_eye_x <= 0;
		right_eye_y <= 0;
		left_eye_x <= 0;
		left_eye_y <= 0;
		nose_x <= 0;
		nose_y <= 0;
		out_stall <= 0;
		cfg_valid <= 0;
		cfg_index <= CFG_EYE_MIN;
		cfg_data <= 0;
		repeat (4) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		test_directed();
		test_random(200);
		set_all(0, 1023, 0, 1023, 1023, 1023, 4095, 7);
		test_random(120);
		set_all(511, 0, 511, 0, 1, 1, 1, 0);
		test_random(40);
		set_all(5, 300, 3, 300, 5, 4, 30, 1);
		send_idle = 78;
		recv_idle = 29;
		test_random(200);
		test_backpressure();
		set_all($urandom_range(40), $urandom_range(120, 1023), $urandom_range(30),
			$urandom_range(100, 1023), $urandom_range(1, 60), $urandom_range(1, 60),
			$urandom_range(1, 400), $urandom_range(7));
		send_idle = 0;
		recv_idle = 0;
		test_random(200);
		set_all(20, 160, 10, 140, 20, 15, 120, 2);
		test_random(100);

		if (errors == 0) begin
			$display("testbench: done, clean");
		end else begin
			$display("testbench: done, errors");
		end
		$finish;
	end

	initial begin
		#20000000;
		$display("testbench: done, errors");
		$finish;
	end

endmodule
